// ===== hw/rtl/xcfr_pkg.sv =====
// ----------------------------------------------------------------------------
// xcfr_pkg - shared types and codes for the checked frame receiver
// Status codes and the result word that travels from the parser to the
// output stage.
// ----------------------------------------------------------------------------
package xcfr_pkg;

   // status codes on the result channel
   localparam logic [1:0] STATUS_HUNTING   = 2'd0;
   localparam logic [1:0] STATUS_RECEIVING = 2'd1;
   localparam logic [1:0] STATUS_VALID_END = 2'd2;
   localparam logic [1:0] STATUS_FAILED    = 2'd3;

   // one result word
   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  opcode;
      logic [31:0] sender_addr;
      logic [31:0] recipient_addr;
      logic [15:0] frame_length;
      logic [10:0] payload_length;
      logic [7:0]  payload_byte;
      logic        payload_strobe;
   } result_type;

endpackage

// ===== hw/rtl/xcfr_parser.sv =====
// ----------------------------------------------------------------------------
// xcfr_parser - magic hunt, header capture and checksum per received byte
// Holds the frame state; for each accepted byte it works out the next state
// and the matching result word in one pass.
// ----------------------------------------------------------------------------
module xcfr_parser
   import xcfr_pkg::*;
#(
   parameter int ADDR_BYTES  = 1,
   parameter int MAX_PAYLOAD = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        take,
   input  logic [7:0]  rx_byte,
   input  logic [15:0] magic_word,
   output result_type  result
);

   localparam int HDR_SIZE = 5 + 2 * ADDR_BYTES;
   localparam logic [15:0] SNDR_END  = 16'(2 + ADDR_BYTES);
   localparam logic [15:0] RCPT_END  = 16'(2 + 2 * ADDR_BYTES);
   localparam logic [15:0] LEN_LO    = RCPT_END;
   localparam logic [15:0] LEN_HI    = RCPT_END + 16'd1;
   localparam logic [15:0] OPC_IDX   = RCPT_END + 16'd2;
   localparam logic [15:0] END_FIRST = 16'(HDR_SIZE - 1);
   localparam logic [16:0] LEN_MIN   = 17'(HDR_SIZE + 1);
   localparam logic [16:0] LEN_MAX   = 17'(MAX_PAYLOAD + HDR_SIZE + 1);

   typedef enum logic {
      PH_HUNT,
      PH_RECV
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  last_byte_ff, last_byte_in;
   logic        last_seen_ff, last_seen_in;
   logic [15:0] taken_ff, taken_in;
   logic [7:0]  xor_ff, xor_in;
   logic [31:0] sender_ff, sender_in;
   logic [31:0] recipient_ff, recipient_in;
   logic [15:0] length_ff, length_in;
   logic [7:0]  opcode_ff, opcode_in;

   logic        len_ok;
   logic [16:0] len_wide;
   logic [16:0] len_rest;

   // next state and result word for the byte on offer
   always_comb begin
      logic [15:0] idx;
      logic [1:0]  lane;
      logic        failed;
      logic [1:0]  status;
      logic [7:0]  pbyte;
      logic        strobe;
      logic        hi_ok;

      phase_in     = phase_ff;
      last_byte_in = last_byte_ff;
      last_seen_in = last_seen_ff;
      taken_in     = taken_ff;
      xor_in       = xor_ff;
      sender_in    = sender_ff;
      recipient_in = recipient_ff;
      length_in    = length_ff;
      opcode_in    = opcode_ff;
      idx          = taken_ff;
      lane         = 2'd0;
      failed       = 1'b0;
      status       = STATUS_HUNTING;
      pbyte        = 8'd0;
      strobe       = 1'b0;
      hi_ok        = 1'b0;

      if (phase_ff == PH_HUNT) begin
         if (last_seen_ff && last_byte_ff == magic_word[7:0]
             && rx_byte == magic_word[15:8]) begin
            phase_in     = PH_RECV;
            taken_in     = 16'd2;
            xor_in       = last_byte_ff ^ rx_byte;
            sender_in    = '0;
            recipient_in = '0;
            length_in    = '0;
            opcode_in    = '0;
            last_seen_in = 1'b0;
            status       = STATUS_RECEIVING;
         end else begin
            last_byte_in = rx_byte;
            last_seen_in = 1'b1;
         end
      end else begin
         xor_in   = xor_ff ^ rx_byte;
         taken_in = taken_ff + 16'd1;
         status   = STATUS_RECEIVING;

         if (idx < SNDR_END) begin
            lane = 2'(idx - 16'd2);
            sender_in[8*lane +: 8] = sender_ff[8*lane +: 8] | rx_byte;
         end else if (idx < RCPT_END) begin
            lane = 2'(idx - SNDR_END);
            recipient_in[8*lane +: 8] = recipient_ff[8*lane +: 8] | rx_byte;
         end else if (idx == LEN_LO) begin
            length_in = {8'd0, rx_byte};
         end else if (idx == LEN_HI) begin
            length_in = {rx_byte, length_ff[7:0]};
            hi_ok = ({1'b0, length_in} >= LEN_MIN) && ({1'b0, length_in} <= LEN_MAX);
            failed = !hi_ok;
         end else if (idx == OPC_IDX) begin
            opcode_in = rx_byte;
         end else if (({1'b0, idx} + 17'd1) < {1'b0, length_ff}) begin
            pbyte  = rx_byte;
            strobe = 1'b1;
         end

         if (failed) begin
            status   = STATUS_FAILED;
            phase_in = PH_HUNT;
         end else if (idx >= END_FIRST && taken_in == length_in) begin
            status   = (xor_in == 8'd0) ? STATUS_VALID_END : STATUS_FAILED;
            phase_in = PH_HUNT;
         end
      end

      result.status         = status;
      result.opcode         = opcode_in;
      result.sender_addr    = sender_in;
      result.recipient_addr = recipient_in;
      result.frame_length   = length_in;
      result.payload_length = len_ok ? len_rest[10:0] : 11'd0;
      result.payload_byte   = pbyte;
      result.payload_strobe = strobe;
   end

   // payload length from the updated length field
   assign len_wide = {1'b0, length_in};
   assign len_ok   = (len_wide >= LEN_MIN) && (len_wide <= LEN_MAX);
   assign len_rest = len_wide - LEN_MIN;

   // frame state, moves on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         last_byte_ff <= '0;
         last_seen_ff <= 1'b0;
         taken_ff     <= '0;
         xor_ff       <= '0;
         sender_ff    <= '0;
         recipient_ff <= '0;
         length_ff    <= '0;
         opcode_ff    <= '0;
      end else if (take) begin
         phase_ff     <= phase_in;
         last_byte_ff <= last_byte_in;
         last_seen_ff <= last_seen_in;
         taken_ff     <= taken_in;
         xor_ff       <= xor_in;
         sender_ff    <= sender_in;
         recipient_ff <= recipient_in;
         length_ff    <= length_in;
         opcode_ff    <= opcode_in;
      end
   end

   // inside a frame the count starts at two, past the magic
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_RECV |-> taken_ff >= 16'd2)
      else $error("byte count below magic size inside a frame");

   // a payload byte only shows while a frame is running
   assert property (@(posedge clock) disable iff (reset)
      result.payload_strobe |-> phase_ff == PH_RECV && result.status == STATUS_RECEIVING)
      else $error("payload strobe outside a frame");

   // an ended or failed frame drops back to the hunt
   assert property (@(posedge clock) disable iff (reset)
      take && (result.status == STATUS_VALID_END || result.status == STATUS_FAILED)
      |=> phase_ff == PH_HUNT)
      else $error("frame end did not return to hunting");

   // a magic match starts a frame with the count at two and the held byte cleared
   assert property (@(posedge clock) disable iff (reset)
      take && phase_ff == PH_HUNT && result.status == STATUS_RECEIVING
      |=> taken_ff == 16'd2 && !last_seen_ff)
      else $error("magic match did not start a frame cleanly");

endmodule

// ===== hw/rtl/xor_checked_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// xor_checked_frame_receiver - magic-framed byte receiver with XOR check
// The result word of an accepted byte is registered in the output word, or in the skid word.
// Throughput: one byte per cycle while req_stall is low, set by the single-pass parser update.
// A two-word output stage keeps input open while one result waits.
// Reset: synchronous, active high; parser hunts, magic word reads zero.
// ----------------------------------------------------------------------------
module xor_checked_frame_receiver
   import xcfr_pkg::*;
#(
   parameter int ADDR_BYTES  = 1,
   parameter int MAX_PAYLOAD = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   // byte input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   // result output
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_opcode,
   output logic [31:0] rsp_sender_addr,
   output logic [31:0] rsp_recipient_addr,
   output logic [15:0] rsp_frame_length,
   output logic [10:0] rsp_payload_length,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_payload_strobe
);

   logic [15:0] magic_ff;
   logic        take;
   logic        give;
   result_type  result;
   result_type  out_ff;
   result_type  skid_ff;
   logic        out_valid_ff;
   logic        skid_valid_ff;

   // magic word register
   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff <= '0;
      end else if (csr_write_enable) begin
         magic_ff <= csr_write_data;
      end
   end

   assign req_stall = skid_valid_ff;
   assign take      = req_valid && !skid_valid_ff;
   assign give      = out_valid_ff && !rsp_stall;

   xcfr_parser #(
      .ADDR_BYTES  (ADDR_BYTES),
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .rx_byte    (req_rx_byte),
      .magic_word (magic_ff),
      .result     (result)
   );

   // output word plus skid word
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (give) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (take) begin
         if (!out_valid_ff || give) begin
            out_ff       <= result;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= result;
            skid_valid_ff <= 1'b1;
         end
      end else if (give) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_status         = out_ff.status;
   assign rsp_opcode         = out_ff.opcode;
   assign rsp_sender_addr    = out_ff.sender_addr;
   assign rsp_recipient_addr = out_ff.recipient_addr;
   assign rsp_frame_length   = out_ff.frame_length;
   assign rsp_payload_length = out_ff.payload_length;
   assign rsp_payload_byte   = out_ff.payload_byte;
   assign rsp_payload_strobe = out_ff.payload_strobe;

   // the skid word only fills behind a waiting output word
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held without output word");

   // a stalled output word is not dropped
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall |=> out_valid_ff)
      else $error("stalled result word lost");

   // a drained skid word empties the skid stage
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp_stall |=> !skid_valid_ff)
      else $error("skid word not moved on when output taken");

endmodule
